>>> sv/fqi_pkg.sv
`default_nettype none
package fqi_pkg;

   // Width of one stored word and of the item's mode field.
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned COUNT_W = 5;

   // Operation codes carried by the mode field of an item.
   localparam logic [MODE_W-1:0] MODE_ENQ   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DEQ   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_INC   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUERY = 3'd4;

   // What a storage cell does with its word on a clock edge.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_INC,
      CELL_LOAD
   } cell_op_type;

   // Control bundle from the queue controller to one cell.
   typedef struct packed {
      cell_op_type op;
   } cell_ctl_type;

endpackage
`default_nettype wire

>>> sv/fqi_cell.sv
`default_nettype none
module fqi_cell (
   input  wire logic                             clock,
   input  wire fqi_pkg::cell_ctl_type            ctl,
   input  wire logic signed [fqi_pkg::WORD_W-1:0] load_data,
   input  wire logic signed [fqi_pkg::WORD_W-1:0] neighbour_data,
   output logic signed [fqi_pkg::WORD_W-1:0]     word
);
   import fqi_pkg::*;

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;

   // Choose the next word: keep it, take the neighbour's, add one or load a new item.
   always_comb begin
      unique case (ctl.op)
         CELL_HOLD:  word_in = word_ff;
         CELL_SHIFT: word_in = neighbour_data;
         CELL_INC:   word_in = word_ff + WORD_W'(1);
         CELL_LOAD:  word_in = load_data;
         default:    word_in = word_ff;
      endcase
   end

   // The stored word needs no reset: only occupied cells are ever read.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule
`default_nettype wire

>>> sv/fifo_queue_with_increment_all_core.sv
// The result of an accepted item is captured in the output register and offered in the next cycle.
// Throughput: one item per cycle; every operation acts on the whole row of cells at once.
// The input is stalled only while a result waits in the output register and is itself stalled.
// Reset (synchronous, active high) empties the queue and clears the output valid flag;
// the stored words are not cleared and are never read before being written.
`default_nettype none
module fifo_queue_with_increment_all_core #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [fqi_pkg::MODE_W-1:0]        req_mode,
   input  wire logic signed [fqi_pkg::WORD_W-1:0] req_data_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [fqi_pkg::WORD_W-1:0]      rsp_data_out,
   output logic                                   rsp_error_flag,
   output logic [fqi_pkg::COUNT_W-1:0]            rsp_entry_count,
   output logic                                   rsp_not_empty
);
   import fqi_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [WORD_W-1:0]  rsp_data_ff;
   logic signed [WORD_W-1:0]  rsp_data_in;
   logic                      rsp_error_ff;
   logic                      rsp_error_in;
   logic [CW-1:0]             rsp_count_ff;
   logic                      accept;
   logic                      empty;
   logic                      full;
   cell_op_type               row_op;
   logic signed [WORD_W-1:0]  words [DEPTH];
   logic [CW+COUNT_W-1:0]     count_ext;

   // Handshake: a new item is taken unless the pending result is held up.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(DEPTH));

   // Decode the item into a row operation, the result and the next count.
   always_comb begin
      row_op       = CELL_HOLD;
      rsp_data_in  = '0;
      rsp_error_in = 1'b0;
      count_in     = count_ff;
      if (accept) begin
         unique case (req_mode)
            MODE_ENQ: begin
               if (full) begin
                  rsp_error_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            MODE_DEQ: begin
               if (empty) begin
                  rsp_error_in = 1'b1;
               end else begin
                  row_op      = CELL_SHIFT;
                  rsp_data_in = words[0];
                  count_in    = count_ff - CW'(1);
               end
            end
            MODE_PEEK: begin
               if (empty) begin
                  rsp_error_in = 1'b1;
               end else begin
                  rsp_data_in = words[0];
               end
            end
            MODE_INC: begin
               row_op = CELL_INC;
            end
            default: begin
               row_op = CELL_HOLD;
            end
         endcase
      end
   end

   // Row of cells: the head sits in cell zero and each cell but the last takes from its right neighbour.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctl_type             ctl;
      logic signed [WORD_W-1:0] neighbour;

      always_comb begin
         ctl.op = row_op;
         if (accept && (req_mode == MODE_ENQ) && !full && (count_ff == CW'(i))) begin
            ctl.op = CELL_LOAD;
         end
      end

      if (i == DEPTH - 1) begin : g_last
         assign neighbour = words[i];
      end else begin : g_inner
         assign neighbour = words[i+1];
      end

      fqi_cell u_cell (
         .clock          (clock),
         .ctl            (ctl),
         .load_data      (req_data_in),
         .neighbour_data (neighbour),
         .word           (words[i])
      );
   end

   // The output register is loaded on acceptance and emptied once the result is taken.
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload is captured only when an item is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_error_ff <= rsp_error_in;
         rsp_count_ff <= count_in;
      end
   end

   // The reported count is the occupancy reduced to five bits.
   assign count_ext       = (CW + COUNT_W)'(rsp_count_ff);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_error_flag  = rsp_error_ff;
   assign rsp_entry_count = count_ext[COUNT_W-1:0];
   assign rsp_not_empty   = (rsp_count_ff != '0);

endmodule
`default_nettype wire

>>> sv/fqi_checker.sv
`default_nettype none
module fqi_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic signed [fqi_pkg::WORD_W-1:0] rsp_data_out,
   input wire logic                              rsp_error_flag,
   input wire logic [fqi_pkg::COUNT_W-1:0]       rsp_entry_count,
   input wire logic                              rsp_not_empty
);
   import fqi_pkg::*;

   // A result that is held up stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // Every accepted item produces a result in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item gave no result");

   // A failed operation never returns a value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> rsp_data_out == '0)
      else $error("error result carries data");

   // Nothing is offered in the cycle after a reset edge.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // An error reported with no entries left must show a zero count.
   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag && !rsp_not_empty |-> rsp_entry_count == '0)
      else $error("empty error with nonzero count");

endmodule

bind fifo_queue_with_increment_all_core fqi_checker u_fqi_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_data_out    (rsp_data_out),
   .rsp_error_flag  (rsp_error_flag),
   .rsp_entry_count (rsp_entry_count),
   .rsp_not_empty   (rsp_not_empty)
);
`default_nettype wire

>>> test/fifo_queue_with_increment_all_core_tb.sv
module fifo_queue_with_increment_all_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fqi_pkg::*;

   localparam int unsigned DEPTH = 16;
   localparam logic [MODE_W-1:0] MODE_UNDEF_FIRST = MODE_QUERY + 1'b1;
   localparam logic [MODE_W-1:0] MODE_UNDEF_LAST  = {MODE_W{1'b1}};

   typedef struct {
      logic signed [WORD_W-1:0] data_out;
      logic                     error_flag;
      logic [COUNT_W-1:0]       entry_count;
      logic                     not_empty;
   } queue_result_type;

   typedef enum {
      TRAFFIC_FILL,
      TRAFFIC_DRAIN,
      TRAFFIC_MIX
   } traffic_kind_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [MODE_W-1:0]         req_mode = MODE_QUERY;
   logic signed [WORD_W-1:0]  req_data_in = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [WORD_W-1:0]  rsp_data_out;
   logic                      rsp_error_flag;
   logic [COUNT_W-1:0]        rsp_entry_count;
   logic                      rsp_not_empty;

   // Predicted queue contents, oldest word at the front.
   logic signed [WORD_W-1:0]  queued_words[$];
   // Results predicted for accepted items and not yet seen at the output.
   queue_result_type          pending_results[$];

   int                        mismatch_count = 0;
   bit                        idling_on = 1'b1;
   int                        stall_left = 0;

   fifo_queue_with_increment_all_core #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_out   (rsp_data_out),
      .rsp_error_flag (rsp_error_flag),
      .rsp_entry_count(rsp_entry_count),
      .rsp_not_empty  (rsp_not_empty)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a generous bound well beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Prints one line per mismatch and counts every one.
   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Applies one operation to the predicted queue and returns its result.
   function automatic queue_result_type apply_queue_op(input logic [MODE_W-1:0] mode,
                                                       input logic signed [WORD_W-1:0] value);
      queue_result_type res;
      res.data_out   = '0;
      res.error_flag = 1'b0;
      case (mode)
         MODE_ENQ: begin
            if (queued_words.size() >= DEPTH) begin
               res.error_flag = 1'b1;
            end else begin
               queued_words.push_back(value);
            end
         end
         MODE_DEQ: begin
            if (queued_words.size() == 0) begin
               res.error_flag = 1'b1;
            end else begin
               res.data_out = queued_words.pop_front();
            end
         end
         MODE_PEEK: begin
            if (queued_words.size() == 0) begin
               res.error_flag = 1'b1;
            end else begin
               res.data_out = queued_words[0];
            end
         end
         MODE_INC: begin
            foreach (queued_words[i]) begin
               queued_words[i] = queued_words[i] + 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.entry_count = COUNT_W'(queued_words.size());
      res.not_empty   = (queued_words.size() != 0);
      return res;
   endfunction

   // Idle length drawn from three ranges: mostly the shortest, rarely the longest.
   function automatic int pick_idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return $urandom_range(1, 2);
      end else if (roll < 92) begin
         return $urandom_range(3, 6);
      end
      return $urandom_range(10, 40);
   endfunction

   // Operation mix that pushes the queue towards full, towards empty, or neither.
   function automatic logic [MODE_W-1:0] pick_mode(input traffic_kind_type kind);
      int roll;
      int enq_share;
      int deq_share;
      roll = $urandom_range(0, 99);
      case (kind)
         TRAFFIC_FILL: begin
            enq_share = 55;
            deq_share = 10;
         end
         TRAFFIC_DRAIN: begin
            enq_share = 15;
            deq_share = 45;
         end
         default: begin
            enq_share = 35;
            deq_share = 25;
         end
      endcase
      if (roll < enq_share) begin
         return MODE_ENQ;
      end else if (roll < enq_share + deq_share) begin
         return MODE_DEQ;
      end else if (roll < enq_share + deq_share + 12) begin
         return MODE_PEEK;
      end else if (roll < enq_share + deq_share + 24) begin
         return MODE_INC;
      end else if (roll < enq_share + deq_share + 32) begin
         return MODE_QUERY;
      end
      return MODE_W'($urandom_range(MODE_UNDEF_FIRST, MODE_UNDEF_LAST));
   endfunction

   // Word values: mostly random, with the wrap-around corners now and then.
   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return -32'sd1;
         3:       return 32'sh7FFF_FFFE;
         default: return $urandom;
      endcase
   endfunction

   // Offers one item, waits for it to be taken, then records its prediction.
   task automatic send_item(input logic [MODE_W-1:0] mode,
                            input logic signed [WORD_W-1:0] value);
      int gap;
      gap = (idling_on && $urandom_range(0, 99) < 30) ? pick_idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_data_in <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(apply_queue_op(mode, value));
   endtask

   // Result side back-pressure, switched off during stretches that run without idle gaps.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 99) < 25) begin
         stall_left = pick_idle_len() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compares every accepted result with the oldest prediction.
   always @(posedge clock) begin : check_results
      queue_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with no item outstanding, data_out %0d",
                                      rsp_data_out));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data_out !== want.data_out)
               report_mismatch($sformatf("data_out %0d, expected %0d",
                                         rsp_data_out, want.data_out));
            if (rsp_error_flag !== want.error_flag)
               report_mismatch($sformatf("error_flag %b, expected %b",
                                         rsp_error_flag, want.error_flag));
            if (rsp_entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count %0d, expected %0d",
                                         rsp_entry_count, want.entry_count));
            if (rsp_not_empty !== want.not_empty)
               report_mismatch($sformatf("not_empty %b, expected %b",
                                         rsp_not_empty, want.not_empty));
         end
      end
   end

   // Every defined operation but enqueue on an empty queue, plus the undefined modes.
   task automatic test_empty_queue();
      send_item(MODE_DEQ, $urandom);
      send_item(MODE_PEEK, $urandom);
      send_item(MODE_INC, $urandom);
      send_item(MODE_QUERY, $urandom);
      for (int m = MODE_UNDEF_FIRST; m <= MODE_UNDEF_LAST; m++) begin
         send_item(m[MODE_W-1:0], $urandom);
      end
   endtask

   // Fills the queue, starting with extreme words, overflows it, wraps it, peeks and dequeues the head.
   task automatic test_fill_wrap_and_drain();
      logic signed [WORD_W-1:0] word;
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            0:       word = 32'sh7FFF_FFFF;
            1:       word = -32'sd1;
            2:       word = 32'sh8000_0000;
            3:       word = '0;
            default: word = $urandom;
         endcase
         send_item(MODE_ENQ, word);
      end
      send_item(MODE_ENQ, 32'sh5A5A_A5A5);
      send_item(MODE_INC, '0);
      send_item(MODE_PEEK, '0);
      send_item(MODE_DEQ, '0);
   endtask

   // Random traffic in stretches that lean towards full, empty or neither.
   task automatic test_random_traffic(input int item_total);
      int sent;
      int stretch;
      traffic_kind_type kind;
      sent = 0;
      while (sent < item_total) begin
         stretch   = $urandom_range(20, 120);
         kind      = traffic_kind_type'($urandom_range(0, 2));
         idling_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < stretch && sent < item_total; i++) begin
            send_item(pick_mode(kind), pick_word());
            sent++;
         end
      end
      idling_on = 1'b1;
   endtask

   // Test sequence.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_fill_wrap_and_drain();
      test_random_traffic(2000);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> fifo_queue_with_increment_all_core.f
sv/fqi_pkg.sv
sv/fqi_cell.sv
sv/fifo_queue_with_increment_all_core.sv
sv/fqi_checker.sv
test/fifo_queue_with_increment_all_core_tb.sv
